// ----- rtl/core/bpl_pkg.sv -----
// Shared types and constants for the bilge pump level controller.
// Holds the configuration struct, the queue word format and the register codes.
// No dependencies.
package bpl_pkg;

	localparam int QUEUE_DEPTH = 4;
	localparam int CFG_IDX_W   = 3;
	localparam int ECHO_W      = 16;
	localparam int LEVEL_W     = 16;
	localparam int PROD_W      = 2 * ECHO_W;
	localparam int DIST_SHIFT  = 9;
	localparam int DIST_W      = PROD_W - DIST_SHIFT;

	localparam logic [2:0] MIN_ECHOES = 3'd3;
	localparam logic [2:0] ALL_ECHOES = 3'd5;

	localparam logic [15:0] RST_SOUND_SPEED = 16'd2248;
	localparam logic [15:0] RST_WELL_HEIGHT = 16'd7680;
	localparam logic [15:0] RST_PUMP_ON     = 16'd2304;
	localparam logic [15:0] RST_PUMP_OFF    = 16'd768;
	localparam logic [3:0]  RST_DEBOUNCE    = 4'd3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SOUND_SPEED = 3'd0,
		REG_WELL_HEIGHT = 3'd1,
		REG_PUMP_ON     = 3'd2,
		REG_PUMP_OFF    = 3'd3,
		REG_DEBOUNCE    = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [15:0] sound_speed_q16;
		logic [15:0] well_height_q8;
		logic [15:0] pump_on_level_q8;
		logic [15:0] pump_off_level_q8;
		logic [3:0]  debounce_count;
	} cfg_t;

	// One classified sensor period as it travels from front to back.
	typedef struct packed {
		logic              emergency;
		logic              fault;
		logic [2:0]        valid_cnt;
		logic [ECHO_W-1:0] median;
	} item_t;

endpackage

// ----- rtl/core/bpl_front.sv -----
// Front end: accepts sensor periods, debounces the float switch,
// counts and sorts the echoes and pushes one classified word to the queue.
// Depends on bpl_pkg.
module bpl_front (
	input  logic           clk,
	input  logic           arst_n,
	input  bpl_pkg::cfg_t  cfg,
	input  logic           in_valid,
	output logic           in_stall,
	input  logic           float_low,
	input  logic [15:0]    echo_a,
	input  logic [15:0]    echo_b,
	input  logic [15:0]    echo_c,
	input  logic [15:0]    echo_d,
	input  logic [15:0]    echo_e,
	input  logic           q_full,
	output logic           push,
	output bpl_pkg::item_t push_item
);
	import bpl_pkg::*;

	logic              valid_s1;
	logic              emergency_s1;
	logic [ECHO_W-1:0] echo_s1 [5];
	logic [3:0]        run_cnt_q;

	logic              accept;
	logic [4:0]        run_next;
	logic [3:0]        run_new;
	logic              emerg_new;
	logic [ECHO_W-1:0] srt [5];
	logic [2:0]        cnt;

	function automatic logic [2*ECHO_W-1:0] order2(input logic [ECHO_W-1:0] a,
			input logic [ECHO_W-1:0] b);
		return (a > b) ? {b, a} : {a, b};
	endfunction

	assign in_stall = valid_s1 & q_full;
	assign accept   = in_valid & ~in_stall;
	assign push     = valid_s1 & ~q_full;

	// Saturating run counter on low float readings.
	always_comb begin
		run_next  = {1'b0, run_cnt_q} + 5'd1;
		run_new   = '0;
		emerg_new = 1'b0;
		if (float_low) begin
			if (run_next >= {1'b0, cfg.debounce_count}) begin
				run_new   = cfg.debounce_count;
				emerg_new = 1'b1;
			end else begin
				run_new = run_next[3:0];
			end
		end
	end

	// Timeouts are zero and sink to the bottom of the sort.
	always_comb begin
		srt = echo_s1;
		{srt[0], srt[1]} = order2(srt[0], srt[1]);
		{srt[3], srt[4]} = order2(srt[3], srt[4]);
		{srt[2], srt[4]} = order2(srt[2], srt[4]);
		{srt[2], srt[3]} = order2(srt[2], srt[3]);
		{srt[1], srt[4]} = order2(srt[1], srt[4]);
		{srt[0], srt[3]} = order2(srt[0], srt[3]);
		{srt[0], srt[2]} = order2(srt[0], srt[2]);
		{srt[1], srt[3]} = order2(srt[1], srt[3]);
		{srt[1], srt[2]} = order2(srt[1], srt[2]);
	end

	always_comb begin
		cnt = '0;
		for (int i = 0; i < 5; i++) begin
			cnt = cnt + {2'b00, (echo_s1[i] != '0)};
		end
	end

	// Median of the nonzero echoes: center for three or five, upper middle for four.
	always_comb begin
		push_item.emergency = emergency_s1;
		push_item.fault     = (cnt < MIN_ECHOES);
		push_item.valid_cnt = cnt;
		push_item.median    = (cnt == ALL_ECHOES) ? srt[2] : srt[3];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			run_cnt_q <= '0;
		end else begin
			if (accept) begin
				valid_s1  <= 1'b1;
				run_cnt_q <= run_new;
			end else if (push) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			emergency_s1 <= emerg_new;
			echo_s1[0]   <= echo_a;
			echo_s1[1]   <= echo_b;
			echo_s1[2]   <= echo_c;
			echo_s1[3]   <= echo_d;
			echo_s1[4]   <= echo_e;
		end
	end

endmodule

// ----- rtl/core/bpl_queue.sv -----
// Short first-in first-out queue of classified words between front and back.
// Depends on bpl_pkg.
module bpl_queue #(
	parameter int DEPTH = bpl_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  bpl_pkg::item_t push_item,
	output logic           full,
	input  logic           pop,
	output logic           not_empty,
	output bpl_pkg::item_t pop_item
);
	import bpl_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	item_t             entries_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_item  = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count past depth");

	a_pop_drains: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !push |=> count_q == $past(count_q) - 1'b1)
		else $error("queue pop lost");

endmodule

// ----- rtl/core/bpl_back.sv -----
// Back end: turns the median echo into a level, holds it across faults,
// runs the pump priority and hysteresis and drives the output register.
// Depends on bpl_pkg.
module bpl_back (
	input  logic           clk,
	input  logic           arst_n,
	input  bpl_pkg::cfg_t  cfg,
	input  logic           q_valid,
	input  bpl_pkg::item_t q_item,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_stall,
	output logic           pump_on,
	output logic           emergency,
	output logic           sensor_fault,
	output logic [15:0]    level_q8,
	output logic [2:0]     valid_echoes
);
	import bpl_pkg::*;

	logic               valid_s2;
	item_t              item_s2;
	logic [PROD_W-1:0]  prod_s2;

	logic               valid_s3;
	logic               pump_on_s3;
	logic               emergency_s3;
	logic               fault_s3;
	logic [LEVEL_W-1:0] level_s3;
	logic [2:0]         valid_cnt_s3;

	logic               pump_q;
	logic [LEVEL_W-1:0] held_level_q;

	logic               load_s3;
	logic               take_s2;
	logic [DIST_W-1:0]  distance;
	logic [DIST_W-1:0]  well_ext;
	logic [LEVEL_W-1:0] level_calc;
	logic [LEVEL_W-1:0] level_new;
	logic               pump_new;

	assign load_s3 = valid_s2 & (~valid_s3 | ~out_stall);
	assign take_s2 = ~valid_s2 | load_s3;
	assign pop     = q_valid & take_s2;

	// Distance in 1/256 cm, then clamp the level at zero.
	always_comb begin
		distance   = prod_s2[PROD_W-1:DIST_SHIFT];
		well_ext   = DIST_W'(cfg.well_height_q8);
		level_calc = (distance >= well_ext) ? '0 : LEVEL_W'(well_ext - distance);
		level_new  = item_s2.fault ? held_level_q : level_calc;
	end

	always_comb begin
		priority if (item_s2.emergency) begin
			pump_new = 1'b1;
		end else if (item_s2.fault) begin
			pump_new = 1'b0;
		end else if (level_new >= cfg.pump_on_level_q8) begin
			pump_new = 1'b1;
		end else if (level_new <= cfg.pump_off_level_q8) begin
			pump_new = 1'b0;
		end else begin
			pump_new = pump_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2     <= 1'b0;
			valid_s3     <= 1'b0;
			pump_q       <= 1'b0;
			held_level_q <= '0;
		end else begin
			if (take_s2) begin
				valid_s2 <= q_valid;
			end
			if (~valid_s3 | ~out_stall) begin
				valid_s3 <= valid_s2;
			end
			if (load_s3) begin
				pump_q       <= pump_new;
				held_level_q <= level_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			item_s2 <= q_item;
			prod_s2 <= PROD_W'(q_item.median) * PROD_W'(cfg.sound_speed_q16);
		end
		if (load_s3) begin
			pump_on_s3   <= pump_new;
			emergency_s3 <= item_s2.emergency;
			fault_s3     <= item_s2.fault;
			level_s3     <= level_new;
			valid_cnt_s3 <= item_s2.valid_cnt;
		end
	end

	assign out_valid    = valid_s3;
	assign pump_on      = pump_on_s3;
	assign emergency    = emergency_s3;
	assign sensor_fault = fault_s3;
	assign level_q8     = level_s3;
	assign valid_echoes = valid_cnt_s3;

	a_emerg_pump: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && emergency_s3 |-> pump_on_s3)
		else $error("emergency without pump");

	a_fault_off: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && fault_s3 && !emergency_s3 |-> !pump_on_s3)
		else $error("pump on during sensor fault");

	a_fault_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> fault_s3 == (valid_cnt_s3 < MIN_ECHOES))
		else $error("fault flag disagrees with echo count");

	a_fault_hold: assert property (@(posedge clk) disable iff (!arst_n)
		load_s3 && item_s2.fault |=> held_level_q == $past(held_level_q))
		else $error("held level moved on fault");

endmodule

// ----- rtl/core/bilge_pump_level_control.sv -----
// Top level of the bilge pump level controller: configuration registers,
// front end, word queue and back end. Depends on bpl_pkg, bpl_front,
// bpl_queue and bpl_back.
//
//  channel | direction | handshake               | word
//  --------+-----------+-------------------------+------------------------------------
//  in      | into      | in_valid / in_stall     | float_low, echo_a .. echo_e
//  out     | out of    | out_valid / out_stall   | pump_on, emergency, sensor_fault,
//          |           |                         | level_q8, valid_echoes
//  cfg     | into      | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// One word per clock unless out_stall holds; median sort, 16x16 multiply and the
// level/pump update each own a register stage, so nothing loops across cycles.
// Words pass the front, queue, multiply and output registers in that order.
// arst_n clears all valid bits, the debounce counter, the pump state and the
// held level, and loads the configuration registers with their defaults.
// out_stall backs up the output register, then the multiply stage, then the
// queue; in_stall rises only once the queue is full and the front stage holds.
// cfg_ready is always high; write only while no word is in flight.
module bilge_pump_level_control #(
	parameter int QUEUE_DEPTH = bpl_pkg::QUEUE_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          float_low,
	input  logic [15:0]                   echo_a,
	input  logic [15:0]                   echo_b,
	input  logic [15:0]                   echo_c,
	input  logic [15:0]                   echo_d,
	input  logic [15:0]                   echo_e,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          pump_on,
	output logic                          emergency,
	output logic                          sensor_fault,
	output logic [15:0]                   level_q8,
	output logic [2:0]                    valid_echoes,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [bpl_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]                   cfg_data
);
	import bpl_pkg::*;

	cfg_t  cfg_q;
	logic  q_full;
	logic  push;
	item_t push_item;
	logic  pop;
	logic  q_valid;
	item_t q_item;

	// Writes are always taken; unknown indexes drop the word.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sound_speed_q16   <= RST_SOUND_SPEED;
			cfg_q.well_height_q8    <= RST_WELL_HEIGHT;
			cfg_q.pump_on_level_q8  <= RST_PUMP_ON;
			cfg_q.pump_off_level_q8 <= RST_PUMP_OFF;
			cfg_q.debounce_count    <= RST_DEBOUNCE;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_SOUND_SPEED: cfg_q.sound_speed_q16   <= cfg_data;
				REG_WELL_HEIGHT: cfg_q.well_height_q8    <= cfg_data;
				REG_PUMP_ON:     cfg_q.pump_on_level_q8  <= cfg_data;
				REG_PUMP_OFF:    cfg_q.pump_off_level_q8 <= cfg_data;
				REG_DEBOUNCE:    cfg_q.debounce_count    <= cfg_data[3:0];
				default: begin
				end
			endcase
		end
	end

	// Debounce, echo count and median sort.
	bpl_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.float_low (float_low),
		.echo_a    (echo_a),
		.echo_b    (echo_b),
		.echo_c    (echo_c),
		.echo_d    (echo_d),
		.echo_e    (echo_e),
		.q_full    (q_full),
		.push      (push),
		.push_item (push_item)
	);

	// Decouple classification from the level and pump stages.
	bpl_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.not_empty (q_valid),
		.pop_item  (q_item)
	);

	// Level conversion, held level, pump priority and output register.
	bpl_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.q_valid      (q_valid),
		.q_item       (q_item),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.pump_on      (pump_on),
		.emergency    (emergency),
		.sensor_fault (sensor_fault),
		.level_q8     (level_q8),
		.valid_echoes (valid_echoes)
	);

endmodule
